// ----- sv/rhcw_pkg.sv -----
package rhcw_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SUM_W  = CHAN_W + 1;

  // Hue division: 40 * |delta| / (max - min), quotient at most 40.
  localparam int unsigned HUE_NUM_W = 14;
  localparam int unsigned HUE_DEN_W = CHAN_W;
  localparam int unsigned HUE_Q_W   = 6;

  // Saturation division: (max - min) * 240 / den, quotient at most 240.
  localparam int unsigned SAT_NUM_W = 16;
  localparam int unsigned SAT_DEN_W = SUM_W;
  localparam int unsigned SAT_Q_W   = 8;

  // Quotient bits resolved by each divider stage, and the number of such stages.
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned NUM_STAGES = DIV_STAGES + 2;

  localparam logic [CHAN_W-1:0] SCALE     = 8'd240;
  localparam logic [CHAN_W-1:0] HUE_GREEN = 8'd80;
  localparam logic [CHAN_W-1:0] HUE_BLUE  = 8'd160;

  // floor(S * 240 / 510) = floor(S * 8 / 17) = (S * 7711) >> 14 for S up to 510.
  localparam int unsigned        LUM_RECIP_W = 13;
  localparam logic [12:0]        LUM_RECIP   = 13'd7711;
  localparam int unsigned        LUM_PROD_W  = SUM_W + LUM_RECIP_W;
  localparam int unsigned        LUM_SHIFT   = 14;

  // Luminance <= 120 exactly when S <= 257, and luminance is 0 exactly when S <= 2.
  localparam logic [SUM_W-1:0] SUM_DARK_MAX = 9'd257;
  localparam logic [SUM_W-1:0] SUM_ZERO_MAX = 9'd2;
  localparam logic [SUM_W-1:0] SUM_FULL     = 9'd510;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUE_LOW  = 3'd0,
    CFG_HUE_HIGH = 3'd1,
    CFG_SAT_LOW  = 3'd2,
    CFG_SAT_HIGH = 3'd3,
    CFG_LUM_LOW  = 3'd4,
    CFG_LUM_HIGH = 3'd5
  } rhcw_cfg_e;

  typedef enum logic [1:0] {
    SEC_GRAY  = 2'd0,
    SEC_RED   = 2'd1,
    SEC_GREEN = 2'd2,
    SEC_BLUE  = 2'd3
  } rhcw_sector_e;

  typedef struct packed {
    logic [HUE_NUM_W-1:0] h_rem;
    logic [HUE_DEN_W-1:0] h_den;
    logic [HUE_Q_W-1:0]   h_quo;
    logic                 h_neg;
    rhcw_sector_e         sector;
    logic [SAT_NUM_W-1:0] s_rem;
    logic [SAT_DEN_W-1:0] s_den;
    logic [SAT_Q_W-1:0]   s_quo;
    logic                 s_zero;
    logic [CHAN_W-1:0]    lum;
  } rhcw_pipe_t;

  typedef struct packed {
    logic [CHAN_W-1:0] hue_low;
    logic [CHAN_W-1:0] hue_high;
    logic [CHAN_W-1:0] sat_low;
    logic [CHAN_W-1:0] sat_high;
    logic [CHAN_W-1:0] lum_low;
    logic [CHAN_W-1:0] lum_high;
  } rhcw_window_t;

  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] luminance;
    logic              in_window;
  } rhcw_result_t;

endpackage

// ----- sv/rgb_to_hsl_color_window_match.sv -----
// Converts one 8-bit RGB pixel per clock, while in_stall_o is low, into hue,
// saturation and luminance on a 0..240 scale and flags whether all three lie
// strictly inside the six programmed bounds. The block is a six-stage pipeline:
// one front stage finds max, min and luminance, four divider stages resolve
// two quotient bits of the hue and saturation divisions each, and a final
// stage forms the result and holds it in the output register. out_stall_i
// holds the pipeline, and empty stages still fill while the output waits.
// Bounds are written through the cfg port; the user must write them only
// while no item is in flight, which the block does not enforce. Index 0..5
// selects hue_low, hue_high, sat_low, sat_high, lum_low, lum_high; others are ignored.
module rgb_to_hsl_color_window_match (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rhcw_pkg::CHAN_W-1:0]         red_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]         green_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]         blue_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rhcw_pkg::CHAN_W-1:0]         hue_o,
  output logic [rhcw_pkg::CHAN_W-1:0]         saturation_o,
  output logic [rhcw_pkg::CHAN_W-1:0]         luminance_o,
  output logic                                in_window_o,
  input  logic                                cfg_we_i,
  input  logic [rhcw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]         cfg_data_i
);

  localparam int unsigned NStg = rhcw_pkg::NUM_STAGES;

  rhcw_pkg::rhcw_window_t win_q;
  rhcw_pkg::rhcw_result_t res;
  rhcw_pkg::rhcw_pipe_t   pipe [rhcw_pkg::DIV_STAGES+1];
  logic [NStg-1:0]        vld;
  logic [NStg-1:0]        rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.hue_low  <= '0;
      win_q.hue_high <= '1;
      win_q.sat_low  <= '0;
      win_q.sat_high <= '1;
      win_q.lum_low  <= '0;
      win_q.lum_high <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rhcw_pkg::CFG_HUE_LOW:  win_q.hue_low  <= cfg_data_i;
        rhcw_pkg::CFG_HUE_HIGH: win_q.hue_high <= cfg_data_i;
        rhcw_pkg::CFG_SAT_LOW:  win_q.sat_low  <= cfg_data_i;
        rhcw_pkg::CFG_SAT_HIGH: win_q.sat_high <= cfg_data_i;
        rhcw_pkg::CFG_LUM_LOW:  win_q.lum_low  <= cfg_data_i;
        rhcw_pkg::CFG_LUM_HIGH: win_q.lum_high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    rdy[NStg-1] = !vld[NStg-1] || !out_stall_i;
    for (int k = int'(NStg) - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];

  rhcw_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (rdy[0]),
    .valid_i (in_valid_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (vld[0]),
    .data_o  (pipe[0])
  );

  for (genvar k = 0; k < int'(rhcw_pkg::DIV_STAGES); k++) begin : g_div
    rhcw_div_stage #(
      .STAGE (k)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (rdy[k+1]),
      .valid_i (vld[k]),
      .data_i  (pipe[k]),
      .valid_o (vld[k+1]),
      .data_o  (pipe[k+1])
    );
  end

  rhcw_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (rdy[NStg-1]),
    .valid_i  (vld[NStg-2]),
    .data_i   (pipe[rhcw_pkg::DIV_STAGES]),
    .window_i (win_q),
    .valid_o  (vld[NStg-1]),
    .res_o    (res)
  );

  assign out_valid_o  = vld[NStg-1];
  assign hue_o        = res.hue;
  assign saturation_o = res.saturation;
  assign luminance_o  = res.luminance;
  assign in_window_o  = res.in_window;

`ifndef SYNTHESIS
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hue_o <= rhcw_pkg::SCALE) && (saturation_o <= rhcw_pkg::SCALE) &&
                    (luminance_o <= rhcw_pkg::SCALE))
    else $error("result outside 0..240");

  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_window_o) |-> (hue_o > win_q.hue_low) && (hue_o < win_q.hue_high) &&
                                     (saturation_o > win_q.sat_low) &&
                                     (saturation_o < win_q.sat_high) &&
                                     (luminance_o > win_q.lum_low) &&
                                     (luminance_o < win_q.lum_high))
    else $error("window flag set outside the bounds");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld[0])
    else $error("accepted item did not enter the first stage");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld) && out_stall_i) |-> in_stall_o)
    else $error("input taken while the pipeline is full and held");

  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (luminance_o == '0)) |-> (saturation_o == '0))
    else $error("saturation set on a black pixel");
`endif

endmodule

// ----- sv/rhcw_front.sv -----
module rhcw_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]         red_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]         green_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]         blue_i,
  output logic                                valid_o,
  output rhcw_pkg::rhcw_pipe_t                data_o
);

  logic                                 valid_q;
  rhcw_pkg::rhcw_pipe_t                 data_d, data_q;
  logic [rhcw_pkg::CHAN_W-1:0]          hi, lo, diff, mag;
  logic [rhcw_pkg::SUM_W-1:0]           sum, den;
  logic                                 neg;
  rhcw_pkg::rhcw_sector_e               sector;
  logic [rhcw_pkg::LUM_PROD_W-1:0]      lum_prod;

  always_comb begin
    hi = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i > hi) hi = blue_i;
    lo = red_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo) lo = blue_i;
    diff = hi - lo;
    sum  = {1'b0, hi} + {1'b0, lo};

    // Ties go to red first, then green, as the hue sectors are defined.
    if (diff == '0) begin
      sector = rhcw_pkg::SEC_GRAY;
      neg    = 1'b0;
      mag    = '0;
    end else if (hi == red_i) begin
      sector = rhcw_pkg::SEC_RED;
      neg    = green_i < blue_i;
      mag    = neg ? blue_i - green_i : green_i - blue_i;
    end else if (hi == green_i) begin
      sector = rhcw_pkg::SEC_GREEN;
      neg    = blue_i < red_i;
      mag    = neg ? red_i - blue_i : blue_i - red_i;
    end else begin
      sector = rhcw_pkg::SEC_BLUE;
      neg    = red_i < green_i;
      mag    = neg ? green_i - red_i : red_i - green_i;
    end

    den = (sum <= rhcw_pkg::SUM_DARK_MAX) ? sum : rhcw_pkg::SUM_FULL - sum;
    lum_prod = rhcw_pkg::LUM_PROD_W'(sum) * rhcw_pkg::LUM_PROD_W'(rhcw_pkg::LUM_RECIP);

    data_d.h_rem  = (rhcw_pkg::HUE_NUM_W'(mag) << 5) + (rhcw_pkg::HUE_NUM_W'(mag) << 3);
    data_d.h_den  = diff;
    data_d.h_quo  = '0;
    data_d.h_neg  = neg;
    data_d.sector = sector;
    data_d.s_rem  = (rhcw_pkg::SAT_NUM_W'(diff) << 8) - (rhcw_pkg::SAT_NUM_W'(diff) << 4);
    data_d.s_den  = den;
    data_d.s_quo  = '0;
    data_d.s_zero = (diff == '0) || (sum <= rhcw_pkg::SUM_ZERO_MAX) || (den == '0);
    data_d.lum    = lum_prod[rhcw_pkg::LUM_SHIFT +: rhcw_pkg::CHAN_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- sv/rhcw_div_stage.sv -----
module rhcw_div_stage #(
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rhcw_pkg::rhcw_pipe_t data_i,
  output logic                 valid_o,
  output rhcw_pkg::rhcw_pipe_t data_o
);

  localparam int HueTop = int'(rhcw_pkg::HUE_Q_W) - 1 - int'(STAGE * rhcw_pkg::DIV_STEPS);
  localparam int SatTop = int'(rhcw_pkg::SAT_Q_W) - 1 - int'(STAGE * rhcw_pkg::DIV_STEPS);

  logic                 valid_q;
  rhcw_pkg::rhcw_pipe_t data_d, data_q;
  logic [rhcw_pkg::HUE_NUM_W-1:0] h_cmp;
  logic [rhcw_pkg::SAT_NUM_W-1:0] s_cmp;

  // Restoring division: each step tries the divisor shifted to the current
  // quotient bit and shifts the outcome into the quotient.
  always_comb begin
    data_d = data_i;
    h_cmp  = '0;
    s_cmp  = '0;
    for (int j = 0; j < int'(rhcw_pkg::DIV_STEPS); j++) begin
      if (HueTop - j >= 0) begin
        h_cmp = rhcw_pkg::HUE_NUM_W'(data_d.h_den) << (HueTop - j);
        if (data_d.h_rem >= h_cmp) begin
          data_d.h_rem = data_d.h_rem - h_cmp;
          data_d.h_quo = {data_d.h_quo[rhcw_pkg::HUE_Q_W-2:0], 1'b1};
        end else begin
          data_d.h_quo = {data_d.h_quo[rhcw_pkg::HUE_Q_W-2:0], 1'b0};
        end
      end
      if (SatTop - j >= 0) begin
        s_cmp = rhcw_pkg::SAT_NUM_W'(data_d.s_den) << (SatTop - j);
        if (data_d.s_rem >= s_cmp) begin
          data_d.s_rem = data_d.s_rem - s_cmp;
          data_d.s_quo = {data_d.s_quo[rhcw_pkg::SAT_Q_W-2:0], 1'b1};
        end else begin
          data_d.s_quo = {data_d.s_quo[rhcw_pkg::SAT_Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- sv/rhcw_back.sv -----
module rhcw_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  rhcw_pkg::rhcw_pipe_t   data_i,
  input  rhcw_pkg::rhcw_window_t window_i,
  output logic                   valid_o,
  output rhcw_pkg::rhcw_result_t res_o
);

  logic                        valid_q;
  rhcw_pkg::rhcw_result_t      res_d, res_q;
  logic [rhcw_pkg::CHAN_W-1:0] quo;

  // Every hue and saturation value formed here already lies within 0..240,
  // so no clamping is needed.
  always_comb begin
    quo = rhcw_pkg::CHAN_W'(data_i.h_quo);
    case (data_i.sector)
      rhcw_pkg::SEC_RED: begin
        res_d.hue = data_i.h_neg ? rhcw_pkg::SCALE - quo : quo;
      end
      rhcw_pkg::SEC_GREEN: begin
        res_d.hue = data_i.h_neg ? rhcw_pkg::HUE_GREEN - quo : rhcw_pkg::HUE_GREEN + quo;
      end
      rhcw_pkg::SEC_BLUE: begin
        res_d.hue = data_i.h_neg ? rhcw_pkg::HUE_BLUE - quo : rhcw_pkg::HUE_BLUE + quo;
      end
      default: begin
        res_d.hue = '0;
      end
    endcase
    res_d.saturation = data_i.s_zero ? '0 : data_i.s_quo;
    res_d.luminance  = data_i.lum;
    res_d.in_window  = (res_d.hue > window_i.hue_low) && (res_d.hue < window_i.hue_high) &&
                       (res_d.saturation > window_i.sat_low) &&
                       (res_d.saturation < window_i.sat_high) &&
                       (res_d.luminance > window_i.lum_low) &&
                       (res_d.luminance < window_i.lum_high);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- bench/hsl_window_checker.sv -----
`timescale 1ns / 100ps

module hsl_window_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]    red_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]    green_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]    blue_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]    hue_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]    saturation_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]    luminance_i,
  input  logic                           in_window_i,
  input  logic                           cfg_we_i,
  input  logic [rhcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rhcw_pkg::CHAN_W-1:0]    cfg_data_i,
  output int                             mismatches_o,
  output int                             in_flight_o
);

  rhcw_pkg::rhcw_window_t bounds;
  rhcw_pkg::rhcw_result_t hsl_due_q[$];
  rhcw_pkg::rhcw_result_t want;
  int                     mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  function automatic int clamp_240(input int v);
    if (v < 0) begin
      return 0;
    end
    if (v > 240) begin
      return 240;
    end
    return v;
  endfunction

  function automatic rhcw_pkg::rhcw_result_t predict_hsl_window(
      input logic [rhcw_pkg::CHAN_W-1:0] r8,
      input logic [rhcw_pkg::CHAN_W-1:0] g8,
      input logic [rhcw_pkg::CHAN_W-1:0] b8,
      input rhcw_pkg::rhcw_window_t      win);
    int r, g, b, hi, lo, diff, sum, h, s, l;
    rhcw_pkg::rhcw_result_t res;
    r = int'(r8);
    g = int'(g8);
    b = int'(b8);
    hi = (r > g) ? r : g;
    hi = (b > hi) ? b : hi;
    lo = (r < g) ? r : g;
    lo = (b < lo) ? b : lo;
    diff = hi - lo;
    sum = hi + lo;
    l = (sum * 240) / 255 / 2;
    if (diff == 0) begin
      h = 0;
      s = 0;
    end else begin
      // Signed int division truncates toward zero, so negative hue deltas round up.
      if (hi == r) begin
        h = (40 * (g - b)) / diff;
        if (g < b) begin
          h = h + 240;
        end
      end else if (hi == g) begin
        h = (40 * (b - r)) / diff + 80;
      end else begin
        h = (40 * (r - g)) / diff + 160;
      end
      if (l == 0) begin
        s = 0;
      end else if (l <= 120) begin
        s = (diff * 240) / sum;
      end else if (510 - sum > 0) begin
        s = (diff * 240) / (510 - sum);
      end else begin
        s = 0;
      end
    end
    h = clamp_240(h);
    s = clamp_240(s);
    l = clamp_240(l);
    res.hue = rhcw_pkg::CHAN_W'(h);
    res.saturation = rhcw_pkg::CHAN_W'(s);
    res.luminance = rhcw_pkg::CHAN_W'(l);
    res.in_window = h > int'(win.hue_low) && h < int'(win.hue_high) &&
                    s > int'(win.sat_low) && s < int'(win.sat_high) &&
                    l > int'(win.lum_low) && l < int'(win.lum_high);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds = '{hue_low: 8'd0, hue_high: 8'd255, sat_low: 8'd0, sat_high: 8'd255,
                 lum_low: 8'd0, lum_high: 8'd255};
      hsl_due_q.delete();
      in_flight_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (hsl_due_q.size() == 0) begin
          report_mismatch($sformatf("item h=%0d s=%0d l=%0d w=%0d with no pixel outstanding",
                                    hue_i, saturation_i, luminance_i, in_window_i));
        end else begin
          want = hsl_due_q.pop_front();
          if (hue_i !== want.hue) begin
            report_mismatch($sformatf("hue %0d, expected %0d", hue_i, want.hue));
          end
          if (saturation_i !== want.saturation) begin
            report_mismatch($sformatf("saturation %0d, expected %0d",
                                      saturation_i, want.saturation));
          end
          if (luminance_i !== want.luminance) begin
            report_mismatch($sformatf("luminance %0d, expected %0d",
                                      luminance_i, want.luminance));
          end
          if (in_window_i !== want.in_window) begin
            report_mismatch($sformatf("in_window %0d, expected %0d (h=%0d s=%0d l=%0d)",
                                      in_window_i, want.in_window, want.hue,
                                      want.saturation, want.luminance));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        hsl_due_q.push_back(predict_hsl_window(red_i, green_i, blue_i, bounds));
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          rhcw_pkg::CFG_HUE_LOW:  bounds.hue_low = cfg_data_i;
          rhcw_pkg::CFG_HUE_HIGH: bounds.hue_high = cfg_data_i;
          rhcw_pkg::CFG_SAT_LOW:  bounds.sat_low = cfg_data_i;
          rhcw_pkg::CFG_SAT_HIGH: bounds.sat_high = cfg_data_i;
          rhcw_pkg::CFG_LUM_LOW:  bounds.lum_low = cfg_data_i;
          rhcw_pkg::CFG_LUM_HIGH: bounds.lum_high = cfg_data_i;
          default: ;
        endcase
      end
      in_flight_o <= hsl_due_q.size();
    end
  end

endmodule

// ----- bench/rgb_to_hsl_color_window_match_tb.sv -----
`timescale 1ns / 100ps

module rgb_to_hsl_color_window_match_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [rhcw_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [rhcw_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int NUM_PHASES = 9;

  typedef struct packed {
    logic [rhcw_pkg::CHAN_W-1:0] r;
    logic [rhcw_pkg::CHAN_W-1:0] g;
    logic [rhcw_pkg::CHAN_W-1:0] b;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [rhcw_pkg::CHAN_W-1:0]    red = '0;
  logic [rhcw_pkg::CHAN_W-1:0]    green = '0;
  logic [rhcw_pkg::CHAN_W-1:0]    blue = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [rhcw_pkg::CHAN_W-1:0]    hue;
  logic [rhcw_pkg::CHAN_W-1:0]    saturation;
  logic [rhcw_pkg::CHAN_W-1:0]    luminance;
  logic                           in_window;
  logic                           cfg_we = 1'b0;
  logic [rhcw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rhcw_pkg::CHAN_W-1:0]    cfg_data = '0;

  int          mismatches;
  int          in_flight;
  int unsigned cycle_cnt = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;

  // Corners: gray, primaries, ties between maxima, hue wrap, luminance zero,
  // the dark/bright saturation boundary and the smallest bright denominator.
  pixel_t corner_px [23] = '{
    '{8'd0, 8'd0, 8'd0},       '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
    '{8'd1, 8'd1, 8'd1},       '{8'd255, 8'd0, 8'd0},     '{8'd0, 8'd255, 8'd0},
    '{8'd0, 8'd0, 8'd255},     '{8'd255, 8'd255, 8'd0},   '{8'd0, 8'd255, 8'd255},
    '{8'd255, 8'd0, 8'd255},   '{8'd255, 8'd0, 8'd1},     '{8'd255, 8'd1, 8'd0},
    '{8'd1, 8'd0, 8'd0},       '{8'd2, 8'd0, 8'd0},       '{8'd3, 8'd0, 8'd0},
    '{8'd200, 8'd57, 8'd57},   '{8'd200, 8'd58, 8'd58},   '{8'd255, 8'd254, 8'd254},
    '{8'd254, 8'd255, 8'd255}, '{8'd170, 8'd85, 8'd0},    '{8'd85, 8'd170, 8'd255},
    '{8'd0, 8'd128, 8'd64},    '{8'd64, 8'd0, 8'd128}
  };

  rgb_to_hsl_color_window_match dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .hue_o        (hue),
    .saturation_o (saturation),
    .luminance_o  (luminance),
    .in_window_o  (in_window),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  hsl_window_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .hue_i        (hue),
    .saturation_i (saturation),
    .luminance_i  (luminance),
    .in_window_i  (in_window),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .in_flight_o  (in_flight)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("rgb_to_hsl_color_window_match_tb failed");
      $finish;
    end
  end

  // Output back-pressure comes in bursts; stall_left counts the stalled cycles still to come.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 18);
    end
    out_stall <= (stall_left != 0);
  end

  function automatic pixel_t random_pixel();
    pixel_t px;
    int     base;
    px = pixel_t'(24'($urandom()));
    case ($urandom_range(0, 9))
      0: begin
        px.g = px.r;
        px.b = px.r;
      end
      1: begin
        base = $urandom_range(0, 251);
        px.r = rhcw_pkg::CHAN_W'(base + $urandom_range(0, 4));
        px.g = rhcw_pkg::CHAN_W'(base + $urandom_range(0, 4));
        px.b = rhcw_pkg::CHAN_W'(base + $urandom_range(0, 4));
      end
      2: begin
        px.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      3: begin
        px.g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    return px;
  endfunction

  function automatic rhcw_pkg::rhcw_window_t pick_window(input int ph);
    rhcw_pkg::rhcw_window_t w;
    w = rhcw_pkg::rhcw_window_t'(48'({$urandom(), $urandom()}));
    case (ph)
      0: w = '{hue_low: 8'd0, hue_high: 8'd255, sat_low: 8'd0, sat_high: 8'd255,
               lum_low: 8'd0, lum_high: 8'd255};
      1: w = '{hue_low: 8'd255, hue_high: 8'd0, sat_low: 8'd255, sat_high: 8'd0,
               lum_low: 8'd255, lum_high: 8'd0};
      2: ;
      3: begin
        w.hue_low = rhcw_pkg::CHAN_W'($urandom_range(0, 220));
        w.hue_high = rhcw_pkg::CHAN_W'(w.hue_low + $urandom_range(2, 35));
        w.sat_low = rhcw_pkg::CHAN_W'($urandom_range(0, 150));
        w.sat_high = rhcw_pkg::CHAN_W'(w.sat_low + $urandom_range(2, 100));
        w.lum_low = rhcw_pkg::CHAN_W'($urandom_range(0, 150));
        w.lum_high = rhcw_pkg::CHAN_W'(w.lum_low + $urandom_range(2, 100));
      end
      default: begin
        w.hue_low = rhcw_pkg::CHAN_W'($urandom_range(0, 100));
        w.hue_high = rhcw_pkg::CHAN_W'($urandom_range(140, 255));
        w.sat_low = rhcw_pkg::CHAN_W'($urandom_range(0, 100));
        w.sat_high = rhcw_pkg::CHAN_W'($urandom_range(140, 255));
        w.lum_low = rhcw_pkg::CHAN_W'($urandom_range(0, 100));
        w.lum_high = rhcw_pkg::CHAN_W'($urandom_range(140, 255));
      end
    endcase
    return w;
  endfunction

  task automatic push_pixel(input pixel_t px);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= px.r;
    green <= px.g;
    blue <= px.b;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every item sent has come back, then lets the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [rhcw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rhcw_pkg::CHAN_W-1:0]    val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_window(input rhcw_pkg::rhcw_window_t w);
    cfg_write(rhcw_pkg::CFG_HUE_LOW, w.hue_low);
    cfg_write(CFG_SPARE_LO, rhcw_pkg::CHAN_W'($urandom()));
    cfg_write(rhcw_pkg::CFG_HUE_HIGH, w.hue_high);
    cfg_write(rhcw_pkg::CFG_SAT_LOW, w.sat_low);
    cfg_write(CFG_SPARE_HI, rhcw_pkg::CHAN_W'($urandom()));
    cfg_write(rhcw_pkg::CFG_SAT_HIGH, w.sat_high);
    cfg_write(rhcw_pkg::CFG_LUM_LOW, w.lum_low);
    cfg_write(rhcw_pkg::CFG_LUM_HIGH, w.lum_high);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner pixels run against the bounds left by reset.
    gap_pct = 10;
    stall_pct = 10;
    foreach (corner_px[i]) begin
      push_pixel(corner_px[i]);
    end
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_window(pick_window(ph));
      if (ph == NUM_PHASES - 1) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = (ph == 1) ? 0 : 8 + 8 * (ph % 3);
        stall_pct = (ph == 4) ? 0 : 6 + 10 * ((ph + 1) % 3);
      end
      repeat ((ph == NUM_PHASES - 1) ? 60 : 100) begin
        push_pixel(random_pixel());
      end
      drain();
    end

    if (mismatches == 0 && in_flight == 0) begin
      $display("rgb_to_hsl_color_window_match_tb passed");
    end else begin
      $display("rgb_to_hsl_color_window_match_tb failed");
    end
    $finish;
  end

endmodule
